### rtl/raip_pkg.sv
// Shared types and constants of the rotate and isometric projection block.
`default_nettype none

package raip_pkg;

	// Field widths
	localparam int PT_W       = 12;
	localparam int Z_W        = 16;
	localparam int COEF_W     = 16;
	localparam int ZOOM_W     = 7;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Fixed point and projection constants
	localparam int FRAC_BITS  = 14;
	localparam int SCREEN_DIV = 5;

	// Product widths of the three rotations and widths of the rotated values
	localparam int PA_W = 32;
	localparam int PB_W = 34;
	localparam int PC_W = 35;
	localparam int R1_W = 18;
	localparam int R2_W = 19;
	localparam int R3_W = 20;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Y = 3'd2,
		REG_SIN_Y = 3'd3,
		REG_COS_Z = 3'd4,
		REG_SIN_Z = 3'd5,
		REG_ZOOM  = 3'd6
	} cfg_reg_t;

	localparam logic signed [COEF_W-1:0] COEF_ONE  = 16'sd16384;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = 16'sd0;
	localparam logic [ZOOM_W-1:0]        ZOOM_RST  = 7'd1;

endpackage

`default_nettype wire

### rtl/rotate_and_isometric_project_top.sv
// Top level: three-axis rotation, screen scaling and isometric projection pipeline.
`default_nettype none

// Channel   | Handshake            | Words
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | point_x, point_y, point_z
// output    | out_valid / out_ready| screen_x, screen_y
// config    | cfg_wr_en            | cfg_index, cfg_data (write only, no wait)
//
// Ten register stages, s1 to s10; an accepted word passes through them in order,
// and out_valid rises once its result is held in the last stage.
// One word may enter every cycle unless a stalled output has filled the stage chain.
// Each stage holds its word while the next one is full and stalled; empty stages
// keep taking words, so input carries on while a result waits at the output.
// Reset clears the stage valid bits and loads the identity rotation, zoom one.

module rotate_and_isometric_project_top #(
	parameter int SCREEN_WIDTH  = 1920,
	parameter int SCREEN_HEIGHT = 1080
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [raip_pkg::PT_W-1:0]            point_x,
	input  wire logic [raip_pkg::PT_W-1:0]            point_y,
	input  wire logic signed [raip_pkg::Z_W-1:0]      point_z,

	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [raip_pkg::OUT_W-1:0]         screen_x,
	output logic signed [raip_pkg::OUT_W-1:0]         screen_y,

	input  wire logic                                 cfg_wr_en,
	input  wire logic [raip_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [raip_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Screen scale and offset, a fifth of each screen dimension
	localparam int W5    = SCREEN_WIDTH / raip_pkg::SCREEN_DIV;
	localparam int H5    = SCREEN_HEIGHT / raip_pkg::SCREEN_DIV;
	localparam int SC_W  = $clog2(((W5 > H5) ? W5 : H5) + 1) + 1;
	localparam int MX_W  = raip_pkg::R3_W + SC_W;
	localparam int SX_W  = MX_W + raip_pkg::ZOOM_W + 2;
	localparam int SS_W  = SX_W + 1;
	localparam int OY_W  = SS_W + 1;
	localparam int FB    = raip_pkg::FRAC_BITS;

	localparam logic signed [SC_W-1:0] W5_C = SC_W'(W5);
	localparam logic signed [SC_W-1:0] H5_C = SC_W'(H5);

	localparam logic signed [raip_pkg::PA_W:0] BIAS_A = (raip_pkg::PA_W+1)'((1 << FB) - 1);
	localparam logic signed [raip_pkg::PB_W:0] BIAS_B = (raip_pkg::PB_W+1)'((1 << FB) - 1);
	localparam logic signed [raip_pkg::PC_W:0] BIAS_C = (raip_pkg::PC_W+1)'((1 << FB) - 1);

	// Clamp to signed 32 bits
	function automatic logic [raip_pkg::OUT_W-1:0] sat32(input logic signed [63:0] v);
		logic [raip_pkg::OUT_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[raip_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic signed [raip_pkg::COEF_W-1:0] cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
	logic [raip_pkg::ZOOM_W-1:0]        zoom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= raip_pkg::COEF_ONE;
			sin_x_q <= raip_pkg::COEF_ZERO;
			cos_y_q <= raip_pkg::COEF_ONE;
			sin_y_q <= raip_pkg::COEF_ZERO;
			cos_z_q <= raip_pkg::COEF_ONE;
			sin_z_q <= raip_pkg::COEF_ZERO;
			zoom_q  <= raip_pkg::ZOOM_RST;
		end else if (cfg_wr_en) begin
			case (raip_pkg::cfg_reg_t'(cfg_index))
				raip_pkg::REG_COS_X: cos_x_q <= cfg_data;
				raip_pkg::REG_SIN_X: sin_x_q <= cfg_data;
				raip_pkg::REG_COS_Y: cos_y_q <= cfg_data;
				raip_pkg::REG_SIN_Y: sin_y_q <= cfg_data;
				raip_pkg::REG_COS_Z: cos_z_q <= cfg_data;
				raip_pkg::REG_SIN_Z: sin_z_q <= cfg_data;
				raip_pkg::REG_ZOOM:  zoom_q  <= cfg_data[raip_pkg::ZOOM_W-1:0];
				default: begin
					// index beyond the register list: drop the write
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Stage flow: a stage advances when it is empty or its successor advances
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;

	assign en_s10 = !v_s10 || out_ready;
	assign en_s9  = !v_s9  || en_s10;
	assign en_s8  = !v_s8  || en_s9;
	assign en_s7  = !v_s7  || en_s8;
	assign en_s6  = !v_s6  || en_s7;
	assign en_s5  = !v_s5  || en_s6;
	assign en_s4  = !v_s4  || en_s5;
	assign en_s3  = !v_s3  || en_s4;
	assign en_s2  = !v_s2  || en_s3;
	assign en_s1  = !v_s1  || en_s2;

	assign in_ready  = en_s1;
	assign out_valid = v_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= in_valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
		end
	end

	// ---------------------------------------------------------------------
	// Datapath
	// ---------------------------------------------------------------------
	// Map coordinates as signed values
	logic signed [raip_pkg::PT_W:0] px_c, py_c;
	assign px_c = $signed({1'b0, point_x});
	assign py_c = $signed({1'b0, point_y});

	// Stage 1: products of the rotation about X
	logic signed [raip_pkg::PA_W-1:0] yc_s1, zs_s1, ys_s1, zc_s1;
	logic signed [raip_pkg::PT_W:0]   x_s1, x_s2;

	// Stage 2: rotated about X
	logic signed [raip_pkg::PA_W:0]   suma_c, sumb_c, adja_c, adjb_c;
	logic signed [raip_pkg::R1_W-1:0] y1_s2, z1_s2;

	assign suma_c = (raip_pkg::PA_W+1)'(yc_s1) + (raip_pkg::PA_W+1)'(zs_s1);
	assign sumb_c = (raip_pkg::PA_W+1)'(zc_s1) - (raip_pkg::PA_W+1)'(ys_s1);
	// bias negative sums so the arithmetic shift truncates toward zero
	assign adja_c = suma_c + (suma_c[raip_pkg::PA_W] ? BIAS_A : '0);
	assign adjb_c = sumb_c + (sumb_c[raip_pkg::PA_W] ? BIAS_A : '0);

	// Stage 3: products of the rotation about Y
	logic signed [raip_pkg::PB_W-1:0] xc_s3, zs_s3, xs_s3, zc_s3;
	logic signed [raip_pkg::R1_W-1:0] y1_s3, y1_s4;

	// Stage 4: rotated about Y
	logic signed [raip_pkg::PB_W:0]   sumc_c, sumd_c, adjc_c, adjd_c;
	logic signed [raip_pkg::R2_W-1:0] x2_s4, z2_s4;

	assign sumc_c = (raip_pkg::PB_W+1)'(xc_s3) + (raip_pkg::PB_W+1)'(zs_s3);
	assign sumd_c = (raip_pkg::PB_W+1)'(zc_s3) - (raip_pkg::PB_W+1)'(xs_s3);
	assign adjc_c = sumc_c + (sumc_c[raip_pkg::PB_W] ? BIAS_B : '0);
	assign adjd_c = sumd_c + (sumd_c[raip_pkg::PB_W] ? BIAS_B : '0);

	// Stage 5: products of the rotation about Z
	logic signed [raip_pkg::PC_W-1:0] xc_s5, ys_s5, xs_s5, yc_s5;
	logic signed [raip_pkg::R2_W-1:0] z2_s5, z2_s6, z2_s7, z2_s8, z2_s9;

	// Stage 6: rotated about Z
	logic signed [raip_pkg::PC_W:0]   sume_c, sumf_c, adje_c, adjf_c;
	logic signed [raip_pkg::R3_W-1:0] x3_s6, y3_s6;

	assign sume_c = (raip_pkg::PC_W+1)'(xc_s5) - (raip_pkg::PC_W+1)'(ys_s5);
	assign sumf_c = (raip_pkg::PC_W+1)'(xs_s5) + (raip_pkg::PC_W+1)'(yc_s5);
	assign adje_c = sume_c + (sume_c[raip_pkg::PC_W] ? BIAS_C : '0);
	assign adjf_c = sumf_c + (sumf_c[raip_pkg::PC_W] ? BIAS_C : '0);

	// Stage 7: screen scale; stage 8: zoom and offset
	logic signed [MX_W-1:0] mx_s7, my_s7;
	logic signed [SX_W-1:0] sx_s8, sy_s8;
	logic signed [raip_pkg::ZOOM_W:0] zoom_c;
	assign zoom_c = $signed({1'b0, zoom_q});

	// Stage 9: projection sums
	logic signed [SS_W-1:0] ox_s9, sum_s9, sadj_c, half_c;
	logic signed [OY_W-1:0] oy_c;

	// halve toward zero, then lift by the negated height
	assign sadj_c = sum_s9 + $signed({{(SS_W-1){1'b0}}, sum_s9[SS_W-1]});
	assign half_c = sadj_c >>> 1;
	assign oy_c   = OY_W'(half_c) - OY_W'(z2_s9);

	// Stage 10: saturated result, held until taken
	logic [raip_pkg::OUT_W-1:0] sx_out_s10, sy_out_s10;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			yc_s1 <= (raip_pkg::PA_W)'(py_c) * (raip_pkg::PA_W)'(cos_x_q);
			zs_s1 <= (raip_pkg::PA_W)'(point_z) * (raip_pkg::PA_W)'(sin_x_q);
			ys_s1 <= (raip_pkg::PA_W)'(py_c) * (raip_pkg::PA_W)'(sin_x_q);
			zc_s1 <= (raip_pkg::PA_W)'(point_z) * (raip_pkg::PA_W)'(cos_x_q);
			x_s1  <= px_c;
		end
		if (en_s2) begin
			y1_s2 <= adja_c[FB+raip_pkg::R1_W-1:FB];
			z1_s2 <= adjb_c[FB+raip_pkg::R1_W-1:FB];
			x_s2  <= x_s1;
		end
		if (en_s3) begin
			xc_s3 <= (raip_pkg::PB_W)'(x_s2) * (raip_pkg::PB_W)'(cos_y_q);
			zs_s3 <= (raip_pkg::PB_W)'(z1_s2) * (raip_pkg::PB_W)'(sin_y_q);
			xs_s3 <= (raip_pkg::PB_W)'(x_s2) * (raip_pkg::PB_W)'(sin_y_q);
			zc_s3 <= (raip_pkg::PB_W)'(z1_s2) * (raip_pkg::PB_W)'(cos_y_q);
			y1_s3 <= y1_s2;
		end
		if (en_s4) begin
			x2_s4 <= adjc_c[FB+raip_pkg::R2_W-1:FB];
			z2_s4 <= adjd_c[FB+raip_pkg::R2_W-1:FB];
			y1_s4 <= y1_s3;
		end
		if (en_s5) begin
			xc_s5 <= (raip_pkg::PC_W)'(x2_s4) * (raip_pkg::PC_W)'(cos_z_q);
			ys_s5 <= (raip_pkg::PC_W)'(y1_s4) * (raip_pkg::PC_W)'(sin_z_q);
			xs_s5 <= (raip_pkg::PC_W)'(x2_s4) * (raip_pkg::PC_W)'(sin_z_q);
			yc_s5 <= (raip_pkg::PC_W)'(y1_s4) * (raip_pkg::PC_W)'(cos_z_q);
			z2_s5 <= z2_s4;
		end
		if (en_s6) begin
			x3_s6 <= adje_c[FB+raip_pkg::R3_W-1:FB];
			y3_s6 <= adjf_c[FB+raip_pkg::R3_W-1:FB];
			z2_s6 <= z2_s5;
		end
		if (en_s7) begin
			mx_s7 <= MX_W'(x3_s6) * MX_W'(W5_C);
			my_s7 <= MX_W'(y3_s6) * MX_W'(H5_C);
			z2_s7 <= z2_s6;
		end
		if (en_s8) begin
			sx_s8 <= SX_W'(mx_s7) * SX_W'(zoom_c) + SX_W'(W5_C);
			sy_s8 <= SX_W'(my_s7) * SX_W'(zoom_c) + SX_W'(H5_C);
			z2_s8 <= z2_s7;
		end
		if (en_s9) begin
			ox_s9  <= SS_W'(sx_s8) - SS_W'(sy_s8);
			sum_s9 <= SS_W'(sx_s8) + SS_W'(sy_s8);
			z2_s9  <= z2_s8;
		end
		if (en_s10) begin
			sx_out_s10 <= sat32(64'(ox_s9));
			sy_out_s10 <= sat32(64'(oy_c));
		end
	end

	assign screen_x = sx_out_s10;
	assign screen_y = sy_out_s10;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	// An empty output stage frees the whole chain
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// A full pipeline behind a stalled output must refuse input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && v_s8 && v_s9 && v_s10
			&& !out_ready) |-> !in_ready)
		else $error("word accepted into a full stalled pipeline");

	// An accepted word occupies the first stage next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted word lost at pipeline entry");

	// A stalled result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(screen_x) && $stable(screen_y)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the rotation and isometric projection pipeline.
`timescale 1ns / 1ps

module testbench;

	localparam int SCREEN_W = 1920;
	localparam int SCREEN_H = 1080;

	// Screen scale and offset, one fifth of each screen dimension
	localparam longint SCALE_X = SCREEN_W / raip_pkg::SCREEN_DIV;
	localparam longint SCALE_Y = SCREEN_H / raip_pkg::SCREEN_DIV;
	localparam longint Q_ONE   = longint'(1) <<< raip_pkg::FRAC_BITS;
	localparam longint HALVING = 2;
	localparam longint OUT_MAX = (longint'(1) <<< (raip_pkg::OUT_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (raip_pkg::OUT_W - 1));

	// Index past the end of the register list; writes to it must be ignored
	localparam logic [raip_pkg::CFG_IDX_W-1:0] REG_BEYOND = 3'd7;

	localparam logic [raip_pkg::COEF_W-1:0] COEF_MIN = 16'h8000;
	localparam logic [raip_pkg::COEF_W-1:0] COEF_MAX = 16'h7FFF;
	localparam logic [raip_pkg::ZOOM_W-1:0] ZOOM_MAX = 7'd127;

	localparam int RANDOM_PHASES  = 10;
	localparam int WORDS_PER_PASS = 143;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct {
		logic signed [raip_pkg::OUT_W-1:0] sx;
		logic signed [raip_pkg::OUT_W-1:0] sy;
	} screen_word_t;

	// Projection predictor and queue of screen words still to arrive
	class projection_scoreboard;
		logic signed [raip_pkg::COEF_W-1:0] coef [6];
		logic [raip_pkg::ZOOM_W-1:0]        zoom;
		screen_word_t                       awaited [$];
		int                                 errors;

		function new();
			coef = '{raip_pkg::COEF_ONE, raip_pkg::COEF_ZERO, raip_pkg::COEF_ONE,
				raip_pkg::COEF_ZERO, raip_pkg::COEF_ONE, raip_pkg::COEF_ZERO};
			zoom = raip_pkg::ZOOM_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [raip_pkg::CFG_IDX_W-1:0] idx,
				logic [raip_pkg::CFG_DATA_W-1:0] data);
			if (idx == raip_pkg::REG_ZOOM) begin
				zoom = data[raip_pkg::ZOOM_W-1:0];
			end else if (idx < raip_pkg::REG_ZOOM) begin
				coef[idx] = data;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// (a*ca + b*cb) in Q2.14, truncated toward zero
		static function longint turn(longint a, longint ca, longint b, longint cb);
			return (a * ca + b * cb) / Q_ONE;
		endfunction

		static function logic signed [raip_pkg::OUT_W-1:0] clamp(longint v);
			if (v > OUT_MAX) return OUT_MAX[raip_pkg::OUT_W-1:0];
			if (v < OUT_MIN) return OUT_MIN[raip_pkg::OUT_W-1:0];
			return v[raip_pkg::OUT_W-1:0];
		endfunction

		function void note_point(logic [raip_pkg::PT_W-1:0] px, logic [raip_pkg::PT_W-1:0] py,
				logic signed [raip_pkg::Z_W-1:0] pz);
			longint c_x, s_x, c_y, s_y, c_z, s_z, zm;
			longint x, y, z, y1, z1, x2, z2, x3, y3, sx, sy;
			screen_word_t w;
			c_x = longint'(coef[raip_pkg::REG_COS_X]);
			s_x = longint'(coef[raip_pkg::REG_SIN_X]);
			c_y = longint'(coef[raip_pkg::REG_COS_Y]);
			s_y = longint'(coef[raip_pkg::REG_SIN_Y]);
			c_z = longint'(coef[raip_pkg::REG_COS_Z]);
			s_z = longint'(coef[raip_pkg::REG_SIN_Z]);
			zm = longint'(zoom);
			x = longint'(px);
			y = longint'(py);
			z = longint'(pz);
			y1 = turn(y, c_x, z, s_x);
			z1 = turn(y, -s_x, z, c_x);
			x2 = turn(x, c_y, z1, s_y);
			z2 = turn(x, -s_y, z1, c_y);
			x3 = turn(x2, c_z, y1, -s_z);
			y3 = turn(x2, s_z, y1, c_z);
			sx = x3 * SCALE_X * zm + SCALE_X;
			sy = y3 * SCALE_Y * zm + SCALE_Y;
			w.sx = clamp(sx - sy);
			w.sy = clamp(-z2 + (sx + sy) / HALVING);
			awaited.push_back(w);
		endfunction

		function void check_result(logic signed [raip_pkg::OUT_W-1:0] ax,
				logic signed [raip_pkg::OUT_W-1:0] ay);
			screen_word_t w;
			if (awaited.size() == 0) begin
				$error("screen word arrived with nothing expected: screen_x %0d screen_y %0d",
					ax, ay);
				errors++;
				return;
			end
			w = awaited.pop_front();
			if (ax !== w.sx) begin
				$error("screen_x mismatch: expected %0d, actual %0d", w.sx, ax);
				errors++;
			end
			if (ay !== w.sy) begin
				$error("screen_y mismatch: expected %0d, actual %0d", w.sy, ay);
				errors++;
			end
		endfunction
	endclass

	logic                                    clk = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    in_valid = 1'b0;
	logic                                    in_ready;
	logic [raip_pkg::PT_W-1:0]               point_x = '0;
	logic [raip_pkg::PT_W-1:0]               point_y = '0;
	logic signed [raip_pkg::Z_W-1:0]         point_z = '0;
	logic                                    out_valid;
	logic                                    out_ready = 1'b0;
	logic signed [raip_pkg::OUT_W-1:0]       screen_x;
	logic signed [raip_pkg::OUT_W-1:0]       screen_y;
	logic                                    cfg_wr_en = 1'b0;
	logic [raip_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
	logic [raip_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

	// Idle rates in percent per cycle, and the request for a long output hold-off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	projection_scoreboard sb;

	rotate_and_isometric_project_top #(
		.SCREEN_WIDTH  (SCREEN_W),
		.SCREEN_HEIGHT (SCREEN_H)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predict each input word as it is taken; check each screen word as it leaves
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.note_point(point_x, point_y, point_z);
		end
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(screen_x, screen_y);
		end
	end

	// Receiver: drop ready at random, or for a long stretch when asked, so the
	// pipeline fills up and pushes back on the input
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one point and hold it until taken; may idle first. Entered and left
	// on a falling edge.
	task automatic send_point(input logic [raip_pkg::PT_W-1:0] px,
			input logic [raip_pkg::PT_W-1:0] py, input logic [raip_pkg::Z_W-1:0] pz);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected screen word has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [raip_pkg::CFG_IDX_W-1:0] idx,
			input logic [raip_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Write all seven registers; junk in the unused zoom bits must be ignored
	task automatic set_rotation(input logic [raip_pkg::COEF_W-1:0] c_x,
			input logic [raip_pkg::COEF_W-1:0] s_x,
			input logic [raip_pkg::COEF_W-1:0] c_y, input logic [raip_pkg::COEF_W-1:0] s_y,
			input logic [raip_pkg::COEF_W-1:0] c_z, input logic [raip_pkg::COEF_W-1:0] s_z,
			input logic [raip_pkg::ZOOM_W-1:0] zm);
		write_reg(raip_pkg::REG_COS_X, c_x);
		write_reg(raip_pkg::REG_SIN_X, s_x);
		write_reg(raip_pkg::REG_COS_Y, c_y);
		write_reg(raip_pkg::REG_SIN_Y, s_y);
		write_reg(raip_pkg::REG_COS_Z, c_z);
		write_reg(raip_pkg::REG_SIN_Z, s_z);
		write_reg(raip_pkg::REG_ZOOM, {9'($urandom), zm});
	endtask

	function automatic logic [raip_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(32768) - 16384);
			2: begin
				case ($urandom_range(4))
					0: return COEF_MIN;
					1: return COEF_MAX;
					2: return raip_pkg::COEF_ONE;
					3: return -raip_pkg::COEF_ONE;
					default: return raip_pkg::COEF_ZERO;
				endcase
			end
			default: return 16'($urandom_range(32768) - 16384);
		endcase
	endfunction

	function automatic logic [raip_pkg::ZOOM_W-1:0] pick_zoom();
		case ($urandom_range(7))
			0: return ZOOM_MAX;
			1: return '0;
			2: return 7'($urandom);
			default: return 7'($urandom_range(64));
		endcase
	endfunction

	function automatic logic [raip_pkg::PT_W-1:0] pick_coord();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [raip_pkg::Z_W-1:0] pick_height();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, sender rarely idle and receiver mostly stalled
		send_idle_pct = 9;
		recv_idle_pct = 71;

		// Reset settings: identity rotation, zoom one
		send_point(12'd0, 12'd0, 16'h0000);
		send_point(12'd4095, 12'd4095, 16'h7FFF);
		send_point(12'd4095, 12'd0, 16'h8000);
		send_point(12'd0, 12'd4095, 16'h8000);
		send_point(12'hAAA, 12'h555, 16'h5555);
		send_point(12'h555, 12'hAAA, 16'hAAAA);
		wait_for_results();

		// A write past the register list must leave every setting alone
		write_reg(REG_BEYOND, 16'($urandom));
		send_point(12'd100, 12'd200, 16'd300);
		wait_for_results();

		// Every coefficient at -2.0, largest zoom: outputs saturate
		set_rotation(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, ZOOM_MAX);
		send_point(12'd4095, 12'd4095, 16'h8000);
		send_point(12'd4095, 12'd4095, 16'h7FFF);
		send_point(12'd0, 12'd0, 16'h7FFF);
		send_point(12'd4095, 12'd0, 16'h0000);
		wait_for_results();

		// Mixed extreme signs, largest zoom: drive the other saturation bound
		set_rotation(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, ZOOM_MAX);
		send_point(12'd4095, 12'd4095, 16'h8000);
		send_point(12'd4095, 12'd4095, 16'h7FFF);
		send_point(12'd0, 12'd4095, 16'h7FFF);
		send_point(12'd4095, 12'd0, 16'h8000);
		wait_for_results();

		// Zero zoom collapses the map onto the screen offset
		set_rotation(raip_pkg::COEF_ONE, raip_pkg::COEF_ZERO, raip_pkg::COEF_ONE,
			raip_pkg::COEF_ZERO, raip_pkg::COEF_ONE, raip_pkg::COEF_ZERO, 7'd0);
		send_point(12'd4095, 12'd4095, 16'h7FFF);
		send_point(12'd1, 12'd2, 16'h8000);
		wait_for_results();

		// Quarter turn about every axis
		set_rotation(raip_pkg::COEF_ZERO, raip_pkg::COEF_ONE, raip_pkg::COEF_ZERO,
			raip_pkg::COEF_ONE, raip_pkg::COEF_ZERO, raip_pkg::COEF_ONE, 7'd1);
		send_point(12'd10, 12'd20, 16'd30);
		send_point(12'd4095, 12'd0, 16'hFFFF);
		send_point(12'd0, 12'd4095, 16'h0001);
		wait_for_results();

		// Random part: a fresh setting per pass, idle pattern changing across passes
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 9;
				recv_idle_pct = 71;
			end else if (ph < 7) begin
				send_idle_pct = 71;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_rotation(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
				pick_coef(), pick_coef(), pick_zoom());
			for (int n = 0; n < WORDS_PER_PASS; n++) begin
				// Hold the output off for a long stretch while words keep coming
				if (ph == 8 && n == 10) begin
					hold_seq <= hold_seq + 1;
				end
				send_point(pick_coord(), pick_coord(), pick_height());
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("rotate_and_isometric_project_top test passed");
		end else begin
			$display("rotate_and_isometric_project_top test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("rotate_and_isometric_project_top test failed");
		$finish;
	end

endmodule
